[sv/sxd_pkg.sv]
`timescale 1ns / 1ps

package sxd_pkg;

  // Operation codes carried by a command item.
  localparam logic [2:0] OP_DRAW  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_LORES = 3'd2;
  localparam logic [2:0] OP_HIRES = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Edge handling codes of the quirk register.
  localparam logic [1:0] QUIRK_ORIG = 2'd0;
  localparam logic [1:0] QUIRK_WRAP = 2'd2;

  // One lane per sprite bit.
  localparam int LANES = 8;

  // Readback is one half line; a line is at most two halves wide.
  localparam int HALF_BITS     = 64;
  localparam int MAX_LINE_BITS = 128;

  // Per-row drawing controls handed to every lane.
  typedef struct packed {
    logic wrap;      // wrap pixels modulo the current size
    logic low_span;  // clip limit is the low resolution width
    logic hires;     // high resolution mode
  } draw_ctl_t;

endpackage

[sv/sxd_channels.sv]
`timescale 1ns / 1ps

interface sxd_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] x_pos;
  logic [7:0] y_pos;
  logic [3:0] row_offset;
  logic [7:0] sprite_byte;
  logic       last_row;
  logic [5:0] read_line;
  logic       read_half;

  modport source (
    output valid, operation, x_pos, y_pos, row_offset, sprite_byte, last_row,
           read_line, read_half,
    input  ready
  );
  modport sink (
    input  valid, operation, x_pos, y_pos, row_offset, sprite_byte, last_row,
           read_line, read_half,
    output ready
  );
endinterface

interface sxd_result_if;
  logic        valid;
  logic        ready;
  logic        collision;
  logic        is_read;
  logic [63:0] display_bits;

  modport source (
    output valid, collision, is_read, display_bits,
    input  ready
  );
  modport sink (
    input  valid, collision, is_read, display_bits,
    output ready
  );
endinterface

[sv/sxd_ram.sv]
`timescale 1ns / 1ps

module sxd_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sxd_lane.sv]
`timescale 1ns / 1ps

module sxd_lane #(
  parameter int W = 128,
  parameter int LANE = 0,
  localparam int XW = $clog2(W),
  localparam int PXW = $clog2(W + 8)
) (
  input  logic              [XW-1:0] x0,
  input  logic                       bit_on,
  input  sxd_pkg::draw_ctl_t         ctl,
  output logic              [W-1:0]  col_mask
);

  localparam int LW = W / 2;

  logic [PXW-1:0] px_raw;
  logic [PXW-1:0] cw;
  logic [PXW-1:0] px;
  logic           px_ok;

  assign px_raw = PXW'(x0) + PXW'(LANE);
  assign cw     = ctl.hires ? PXW'(W) : PXW'(LW);

  // The start is already below the current width, so one subtraction wraps.
  always_comb begin
    if (ctl.wrap) begin
      px    = (px_raw >= cw) ? px_raw - cw : px_raw;
      px_ok = 1'b1;
    end else begin
      px    = px_raw;
      px_ok = ctl.low_span ? (px_raw < PXW'(LW)) : (px_raw < PXW'(W));
    end
  end

  // A low resolution pixel covers two adjacent buffer columns.
  always_comb begin
    for (int c = 0; c < W; c++) begin
      if (ctl.hires) begin
        col_mask[c] = bit_on && px_ok && (PXW'(c) == px);
      end else begin
        col_mask[c] = bit_on && px_ok && (PXW'(c >> 1) == px);
      end
    end
  end

endmodule

[sv/sxd_merge.sv]
`timescale 1ns / 1ps

module sxd_merge #(
  parameter int W = 128
) (
  input  logic [sxd_pkg::LANES-1:0][W-1:0] lane_masks,
  output logic [W-1:0]                     row_mask
);

  always_comb begin
    row_mask = '0;
    for (int i = 0; i < sxd_pkg::LANES; i++) begin
      row_mask = row_mask | lane_masks[i];
    end
  end

endmodule

[sv/sprite_xor_draw_engine_top.sv]
`timescale 1ns / 1ps

// Monochrome XOR sprite frame buffer. A draw item carries one sprite row; the
// start point is wrapped by the screen size chosen through quirk_mode, eight
// parallel lanes place the eight sprite bits on the buffer line, and a merge
// stage ORs them into one row mask that is XORed into one buffer line in high
// resolution or two lines in low resolution, where each pixel is a 2x2 block.
// Collisions are collected across rows and reported in one result item on the
// row marked last_row. Clear, resolution select and read items are also taken;
// a read returns one 64-pixel half line, leftmost pixel in bit 63.
// Items are handled one at a time. The frame buffer is a single-port-read,
// single-port-write memory, so each buffer line costs one read and one write:
// a draw row that lands on screen passes the wrap, lane, modify and finish
// states, with a second modify state in low resolution; a row clipped away
// below the screen skips the memory. A row that returns a result enters the
// emit state, which waits while the previous result is still in the output
// register; a read passes the read data and emit states under the same
// condition, and clear or resolution select are done in idle. Clearing is
// instant through a per-line valid bit, and reset needs no clearing pass. The
// input side accepts a new item while a finished result still waits in the output register.
module sprite_xor_draw_engine_top #(
  parameter int SCREEN_WIDTH = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  sxd_cmd_if.sink             cmd,
  sxd_result_if.source        result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);

  localparam int W   = SCREEN_WIDTH;
  localparam int H   = SCREEN_HEIGHT;
  localparam int LW  = W / 2;
  localparam int LH  = H / 2;
  localparam int AW  = $clog2(H);
  localparam int XW  = $clog2(W);
  localparam int YW  = $clog2(H + 16);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRAP   = 3'd1;
  localparam logic [2:0] ST_LANE   = 3'd2;
  localparam logic [2:0] ST_MOD_A  = 3'd3;
  localparam logic [2:0] ST_MOD_B  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;
  localparam logic [2:0] ST_RDATA  = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  // Remainder of a small value by a constant of at least 16, by restoring
  // compare and subtract over the four possible quotient bits.
  function automatic logic [7:0] wrap_mod(input logic [7:0] v, input logic [10:0] d);
    logic [10:0] r;
    r = {3'b000, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= (d << k)) begin
        r = r - (d << k);
      end
    end
    return r[7:0];
  endfunction

  // Control state.
  logic [2:0]  state;
  logic [1:0]  quirk_mode;
  logic        hires;
  logic        collision_acc;
  logic [H-1:0] row_valid;
  logic        out_valid;

  // Item registers.
  logic [7:0]  x_r;
  logic [7:0]  y_r;
  logic [3:0]  off_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        rd_half;
  logic        rd_inrange;

  // Row stage registers.
  logic [XW-1:0] x0;
  logic          row_ok;
  logic [AW-1:0] line_a;
  logic [AW-1:0] line_b;
  sxd_pkg::draw_ctl_t ctl;
  logic [W-1:0]  mask_r;
  logic          hit_r;

  // Pending result and output register.
  logic        res_collision;
  logic        res_is_read;
  logic [63:0] res_bits;
  logic        out_collision;
  logic        out_is_read;
  logic [63:0] out_bits;

  // Memory port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;
  logic [AW-1:0] rd_row;
  logic [W-1:0]  line_data;

  logic        accept;
  logic        emit_go;

  assign accept  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);
  assign emit_go = (state == ST_EMIT) && (!out_valid || result.ready);

  assign result.valid        = out_valid;
  assign result.collision    = out_collision;
  assign result.is_read      = out_is_read;
  assign result.display_bits = out_bits;

  // A line never written since the last clear reads as dark.
  assign line_data = row_valid[rd_row] ? ram_rdata : '0;

  // ---------------------------------------------------------------------
  // Start point wrap and row placement.
  // ---------------------------------------------------------------------
  logic          span_low;
  logic [7:0]    xm_low, xm_full, ym_low, ym_full;
  logic [YW-1:0] ysum, ch, py;
  logic [YW:0]   la_full, lb_full;
  logic          wrap_q;

  assign wrap_q   = (quirk_mode == sxd_pkg::QUIRK_WRAP);
  assign span_low = (quirk_mode == sxd_pkg::QUIRK_ORIG) || !hires;
  assign xm_low   = wrap_mod(x_r, 11'(LW));
  assign xm_full  = wrap_mod(x_r, 11'(W));
  assign ym_low   = wrap_mod(y_r, 11'(LH));
  assign ym_full  = wrap_mod(y_r, 11'(H));
  assign ysum     = (span_low ? ym_low[YW-1:0] : ym_full[YW-1:0]) + YW'(off_r);
  assign ch       = hires ? YW'(H) : YW'(LH);

  always_comb begin
    if (wrap_q && (ysum >= ch)) begin
      py = ysum - ch;
    end else begin
      py = ysum;
    end
    la_full = hires ? {1'b0, py} : {py, 1'b0};
    lb_full = {py, 1'b1};
  end

  // ---------------------------------------------------------------------
  // Sprite lanes and merge.
  // ---------------------------------------------------------------------
  logic [sxd_pkg::LANES-1:0][W-1:0] lane_masks;
  logic [W-1:0] row_mask;

  for (genvar i = 0; i < sxd_pkg::LANES; i++) begin : g_lane
    sxd_lane #(
      .W    (W),
      .LANE (i)
    ) u_lane (
      .x0       (x0),
      .bit_on   (byte_r[sxd_pkg::LANES-1-i]),
      .ctl      (ctl),
      .col_mask (lane_masks[i])
    );
  end

  sxd_merge #(
    .W (W)
  ) u_merge (
    .lane_masks (lane_masks),
    .row_mask   (row_mask)
  );

  // ---------------------------------------------------------------------
  // Frame buffer.
  // ---------------------------------------------------------------------
  always_comb begin
    ram_raddr = line_a;
    ram_we    = 1'b0;
    ram_waddr = line_a;
    case (state)
      ST_IDLE: begin
        ram_raddr = cmd.read_line[AW-1:0];
      end
      ST_MOD_A: begin
        ram_raddr = line_b;
        ram_we    = 1'b1;
      end
      ST_MOD_B: begin
        ram_we    = 1'b1;
        ram_waddr = line_b;
      end
      default: begin
        ram_raddr = line_a;
      end
    endcase
  end

  assign ram_wdata = line_data ^ mask_r;

  sxd_ram #(
    .WIDTH (W),
    .DEPTH (H)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Readback: pad the line to two halves so that pixels past the width read 0.
  logic [sxd_pkg::MAX_LINE_BITS-1:0] pad;
  logic [63:0] read_bits;

  always_comb begin
    pad = '0;
    if (rd_inrange) begin
      pad[W-1:0] = line_data;
    end
    for (int k = 0; k < sxd_pkg::HALF_BITS; k++) begin
      read_bits[sxd_pkg::HALF_BITS-1-k] = rd_half ? pad[sxd_pkg::HALF_BITS+k] : pad[k];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_row <= ram_raddr;
    if (rst) begin
      state         <= ST_IDLE;
      quirk_mode    <= sxd_pkg::QUIRK_ORIG;
      hires         <= 1'b0;
      collision_acc <= 1'b0;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        quirk_mode <= cfg_wdata;
      end
      if (emit_go) begin
        out_valid     <= 1'b1;
        out_collision <= res_collision;
        out_is_read   <= res_is_read;
        out_bits      <= res_bits;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            x_r        <= cmd.x_pos;
            y_r        <= cmd.y_pos;
            off_r      <= cmd.row_offset;
            byte_r     <= cmd.sprite_byte;
            last_r     <= cmd.last_row;
            rd_half    <= cmd.read_half;
            rd_inrange <= (7'(cmd.read_line) < 7'(H));
            case (cmd.operation)
              sxd_pkg::OP_DRAW:  state <= ST_WRAP;
              sxd_pkg::OP_CLEAR: row_valid <= '0;
              sxd_pkg::OP_LORES: hires <= 1'b0;
              sxd_pkg::OP_HIRES: hires <= 1'b1;
              sxd_pkg::OP_READ:  state <= ST_RDATA;
              default:           state <= ST_IDLE;
            endcase
          end
        end
        ST_WRAP: begin
          x0           <= span_low ? xm_low[XW-1:0] : xm_full[XW-1:0];
          row_ok       <= wrap_q || (ysum < (span_low ? YW'(LH) : YW'(H)));
          line_a       <= la_full[AW-1:0];
          line_b       <= lb_full[AW-1:0];
          ctl.wrap     <= wrap_q;
          ctl.low_span <= span_low;
          ctl.hires    <= hires;
          hit_r        <= 1'b0;
          state        <= ST_LANE;
        end
        ST_LANE: begin
          mask_r <= row_mask;
          state  <= row_ok ? ST_MOD_A : ST_FINISH;
        end
        ST_MOD_A: begin
          row_valid[line_a] <= 1'b1;
          hit_r             <= |(line_data & mask_r);
          state             <= ctl.hires ? ST_FINISH : ST_MOD_B;
        end
        ST_MOD_B: begin
          row_valid[line_b] <= 1'b1;
          hit_r             <= hit_r | (|(line_data & mask_r));
          state             <= ST_FINISH;
        end
        ST_FINISH: begin
          if (last_r) begin
            res_collision <= collision_acc | hit_r;
            res_is_read   <= 1'b0;
            res_bits      <= '0;
            collision_acc <= 1'b0;
            state         <= ST_EMIT;
          end else begin
            collision_acc <= collision_acc | hit_r;
            state         <= ST_IDLE;
          end
        end
        ST_RDATA: begin
          res_collision <= 1'b0;
          res_is_read   <= 1'b1;
          res_bits      <= read_bits;
          state         <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_no_write_idle : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("frame buffer written while idle");

  a_clear_all : assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.operation == sxd_pkg::OP_CLEAR) |=> (row_valid == '0))
    else $error("clear left a line marked written");

  a_acc_cleared : assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && last_r) |=> !collision_acc)
    else $error("collision flag kept after last row");

  a_read_no_hit : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.is_read) |-> !result.collision)
    else $error("read result carries a collision");

endmodule
